// File: src/aaf_pkg.sv
// Package with the shared types, command codes and constants of the accumulator ALU.
package aaf_pkg;

  localparam int unsigned DataWidth = 8;
  localparam int unsigned CmdWidth  = 5;

  typedef logic [DataWidth-1:0] byte_t;

  // Byte mask, used to form the one's complement of the operand for subtract.
  localparam byte_t ByteMask = 8'hFF;

  typedef enum logic [CmdWidth-1:0] {
    CMD_LDA = 5'd0,
    CMD_LDX = 5'd1,
    CMD_LDY = 5'd2,
    CMD_AND = 5'd3,
    CMD_EOR = 5'd4,
    CMD_ORA = 5'd5,
    CMD_BIT = 5'd6,
    CMD_ADC = 5'd7,
    CMD_SBC = 5'd8,
    CMD_CMP = 5'd9,
    CMD_CPX = 5'd10,
    CMD_CPY = 5'd11,
    CMD_INX = 5'd12,
    CMD_DEX = 5'd13,
    CMD_INY = 5'd14,
    CMD_DEY = 5'd15,
    CMD_INC = 5'd16,
    CMD_DEC = 5'd17,
    CMD_ASL = 5'd18,
    CMD_LSR = 5'd19,
    CMD_ROL = 5'd20,
    CMD_ROR = 5'd21
  } cmd_t;

  typedef struct packed {
    byte_t acc;
    byte_t idx_x;
    byte_t idx_y;
    logic  carry;
    logic  zero;
    logic  overflow;
    logic  negative;
  } arch_t;

  typedef struct packed {
    logic [CmdWidth-1:0] command;
    byte_t               operand;
    logic                to_accumulator;
    logic                decimal_flag;
  } item_t;

  typedef struct packed {
    byte_t value_out;
    logic  write_memory;
    logic  carry_out;
    logic  zero_out;
    logic  overflow_out;
    logic  negative_out;
    logic  decimal_error;
  } result_t;

endpackage

// File: src/aaf_if.sv
// Valid/ready channel interfaces for instruction items and their results.
interface aaf_item_if;
  logic                          valid;
  logic                          ready;
  logic [aaf_pkg::CmdWidth-1:0]  command;
  aaf_pkg::byte_t                operand;
  logic                          to_accumulator;
  logic                          decimal_flag;

  modport source (output valid, command, operand, to_accumulator, decimal_flag, input ready);
  modport sink   (input valid, command, operand, to_accumulator, decimal_flag, output ready);
endinterface

interface aaf_result_if;
  logic           valid;
  logic           ready;
  aaf_pkg::byte_t value_out;
  logic           write_memory;
  logic           carry_out;
  logic           zero_out;
  logic           overflow_out;
  logic           negative_out;
  logic           decimal_error;

  modport source (output valid, value_out, write_memory, carry_out, zero_out, overflow_out,
                  negative_out, decimal_error, input ready);
  modport sink   (input valid, value_out, write_memory, carry_out, zero_out, overflow_out,
                  negative_out, decimal_error, output ready);
endinterface

// File: src/accumulator_alu_with_flags.sv
// Top level of the 8-bit accumulator ALU with N, Z, C and V flags.
//
//   Channel  Direction  Payload
//   item     sink       command, operand, to_accumulator, decimal_flag
//   result   source     value_out, write_memory, carry/zero/overflow/negative, decimal_error
//
// An accepted item lands in the input register and is executed by the combinational logic
// against the architectural registers once the result register can take its result; the
// architectural registers update at the same edge as the result register loads.
// Items may be transferred back to back, one per cycle, sustained while the result side is ready.
// Reset clears the accumulator, index registers, flags and both valid bits.
// When the result is stalled, the input register still takes one more item and then
// holds it; the state is only committed when the result register can take the result.
module accumulator_alu_with_flags (
  input  logic                clk,
  input  logic                rst,
  aaf_item_if.sink            item,
  aaf_result_if.source        result
);

  // Input register.
  logic             in_valid;
  aaf_pkg::item_t   in_item;

  // Result register.
  logic             out_valid;
  aaf_pkg::result_t out_res;

  aaf_pkg::arch_t   arch_cur;
  aaf_pkg::arch_t   arch_next;
  aaf_pkg::result_t res_next;

  // The held item executes when the result register is empty or its result is
  // being transferred out in this cycle.
  logic advance;
  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_item.command        <= item.command;
      in_item.operand        <= item.operand;
      in_item.to_accumulator <= item.to_accumulator;
      in_item.decimal_flag   <= item.decimal_flag;
    end
  end

  aaf_alu u_alu (
    .item (in_item),
    .cur  (arch_cur),
    .nxt  (arch_next),
    .res  (res_next)
  );

  aaf_state u_state (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .nxt    (arch_next),
    .cur    (arch_cur)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.value_out     = out_res.value_out;
  assign result.write_memory  = out_res.write_memory;
  assign result.carry_out     = out_res.carry_out;
  assign result.zero_out      = out_res.zero_out;
  assign result.overflow_out  = out_res.overflow_out;
  assign result.negative_out  = out_res.negative_out;
  assign result.decimal_error = out_res.decimal_error;

endmodule

// File: src/aaf_alu.sv
// Combinational execute logic: next architectural state and result for one item.
module aaf_alu (
  input  aaf_pkg::item_t   item,
  input  aaf_pkg::arch_t   cur,
  output aaf_pkg::arch_t   nxt,
  output aaf_pkg::result_t res
);

  aaf_pkg::cmd_t  cmd;
  aaf_pkg::byte_t add_b;
  logic [8:0]     add_sum;
  aaf_pkg::byte_t cmp_reg;
  logic [8:0]     cmp_diff;
  aaf_pkg::byte_t step_src;
  aaf_pkg::byte_t step_res;
  aaf_pkg::byte_t shift_src;
  aaf_pkg::byte_t shl_value;
  aaf_pkg::byte_t shr_value;
  aaf_pkg::byte_t value;
  logic           set_nz;

  assign cmd = aaf_pkg::cmd_t'(item.command);

  // Subtract is add of the complemented operand with the carry as not-borrow.
  assign add_b   = (cmd == aaf_pkg::CMD_SBC) ? (item.operand ^ aaf_pkg::ByteMask) : item.operand;
  assign add_sum = {1'b0, cur.acc} + {1'b0, add_b} + {8'd0, cur.carry};

  always_comb begin
    case (cmd)
      aaf_pkg::CMD_CPX: cmp_reg = cur.idx_x;
      aaf_pkg::CMD_CPY: cmp_reg = cur.idx_y;
      default:          cmp_reg = cur.acc;
    endcase
  end
  // Bit 8 is the borrow, so carry is set when the register is not below the operand.
  assign cmp_diff = {1'b0, cmp_reg} - {1'b0, item.operand};

  always_comb begin
    case (cmd)
      aaf_pkg::CMD_INX, aaf_pkg::CMD_DEX: step_src = cur.idx_x;
      aaf_pkg::CMD_INY, aaf_pkg::CMD_DEY: step_src = cur.idx_y;
      default:                            step_src = item.operand;
    endcase
  end
  assign step_res = (cmd == aaf_pkg::CMD_DEX || cmd == aaf_pkg::CMD_DEY ||
                     cmd == aaf_pkg::CMD_DEC) ? step_src - 8'd1 : step_src + 8'd1;

  assign shift_src = item.to_accumulator ? cur.acc : item.operand;
  assign shl_value = {shift_src[6:0], (cmd == aaf_pkg::CMD_ROL) & cur.carry};
  assign shr_value = {(cmd == aaf_pkg::CMD_ROR) & cur.carry, shift_src[7:1]};

  always_comb begin
    nxt                = cur;
    value              = cur.acc;
    set_nz             = 1'b0;
    res.write_memory   = 1'b0;
    res.decimal_error  = 1'b0;
    case (cmd)
      aaf_pkg::CMD_LDA: begin
        nxt.acc = item.operand;
        value   = item.operand;
        set_nz  = 1'b1;
      end
      aaf_pkg::CMD_LDX: begin
        nxt.idx_x = item.operand;
        value     = item.operand;
        set_nz    = 1'b1;
      end
      aaf_pkg::CMD_LDY: begin
        nxt.idx_y = item.operand;
        value     = item.operand;
        set_nz    = 1'b1;
      end
      aaf_pkg::CMD_AND: begin
        value   = cur.acc & item.operand;
        nxt.acc = value;
        set_nz  = 1'b1;
      end
      aaf_pkg::CMD_EOR: begin
        value   = cur.acc ^ item.operand;
        nxt.acc = value;
        set_nz  = 1'b1;
      end
      aaf_pkg::CMD_ORA: begin
        value   = cur.acc | item.operand;
        nxt.acc = value;
        set_nz  = 1'b1;
      end
      aaf_pkg::CMD_BIT: begin
        nxt.zero     = ((cur.acc & item.operand) == 8'd0);
        nxt.overflow = item.operand[6];
        nxt.negative = item.operand[7];
      end
      aaf_pkg::CMD_ADC, aaf_pkg::CMD_SBC: begin
        if (item.decimal_flag) begin
          // Decimal arithmetic is not supported: report it and leave all state alone.
          res.decimal_error = 1'b1;
        end else begin
          value        = add_sum[7:0];
          nxt.acc      = add_sum[7:0];
          nxt.carry    = add_sum[8];
          nxt.overflow = ~(cur.acc[7] ^ add_b[7]) & (cur.acc[7] ^ add_sum[7]);
          set_nz       = 1'b1;
        end
      end
      aaf_pkg::CMD_CMP, aaf_pkg::CMD_CPX, aaf_pkg::CMD_CPY: begin
        value     = cmp_diff[7:0];
        nxt.carry = ~cmp_diff[8];
        set_nz    = 1'b1;
      end
      aaf_pkg::CMD_INX, aaf_pkg::CMD_DEX: begin
        nxt.idx_x = step_res;
        value     = step_res;
        set_nz    = 1'b1;
      end
      aaf_pkg::CMD_INY, aaf_pkg::CMD_DEY: begin
        nxt.idx_y = step_res;
        value     = step_res;
        set_nz    = 1'b1;
      end
      aaf_pkg::CMD_INC, aaf_pkg::CMD_DEC: begin
        value            = step_res;
        res.write_memory = 1'b1;
        set_nz           = 1'b1;
      end
      aaf_pkg::CMD_ASL, aaf_pkg::CMD_ROL: begin
        value     = shl_value;
        nxt.carry = shift_src[7];
        set_nz    = 1'b1;
        if (item.to_accumulator) begin
          nxt.acc = shl_value;
        end else begin
          res.write_memory = 1'b1;
        end
      end
      aaf_pkg::CMD_LSR, aaf_pkg::CMD_ROR: begin
        value     = shr_value;
        nxt.carry = shift_src[0];
        set_nz    = 1'b1;
        if (item.to_accumulator) begin
          nxt.acc = shr_value;
        end else begin
          res.write_memory = 1'b1;
        end
      end
      default: begin
        value = cur.acc;
      end
    endcase
    if (set_nz) begin
      nxt.zero     = (value == 8'd0);
      nxt.negative = value[7];
    end
    res.value_out    = value;
    res.carry_out    = nxt.carry;
    res.zero_out     = nxt.zero;
    res.overflow_out = nxt.overflow;
    res.negative_out = nxt.negative;
  end

endmodule

// File: src/aaf_state.sv
// Architectural registers: accumulator, index registers and status flags.
module aaf_state (
  input  logic           clk,
  input  logic           rst,
  input  logic           commit,
  input  aaf_pkg::arch_t nxt,
  output aaf_pkg::arch_t cur
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (commit) begin
      cur <= nxt;
    end
  end

endmodule

// File: tb/tb_accumulator_alu_with_flags.sv
// Self-checking testbench for the 8-bit accumulator ALU with N, Z, C and V flags.
module tb_accumulator_alu_with_flags;
  timeunit 1ns;
  timeprecision 1ps;

  import aaf_pkg::*;

  localparam int unsigned HalfPeriod  = 10;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned RandomItems = 900;
  // The block has a two-stage path (input register, result register), so a
  // short tail after the last result is enough to catch stray transfers.
  localparam int unsigned TailCycles  = 10;
  // Hold-off of the result side, long enough to fill both stages and stall the input.
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned MaxReports  = 10;

  // Command codes past the last defined operation must leave everything alone.
  localparam logic [CmdWidth-1:0] CmdUndefined = 5'd31;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aaf_item_if   item_ch ();
  aaf_result_if result_ch ();

  accumulator_alu_with_flags u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always #HalfPeriod clk = ~clk;

  // One row of the directed part. Where the expected result is obvious from the
  // reset state or from an error rule, it is written into the row; the other rows
  // are checked against the predictor.
  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } directed_row_t;

  directed_row_t directed_rows[$];

  // Architectural state as the predictor sees it, and the results still owed.
  arch_t   shadow;
  result_t pending_results[$];

  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned refusals        = 0;
  int unsigned mismatch_count  = 0;
  bit          steady          = 1'b0;
  bit          hold_done       = 1'b0;

  function automatic void add_row(input logic [CmdWidth-1:0] cmd, input byte_t opd,
                                  input logic on_acc = 1'b0, input logic dec = 1'b0,
                                  input bit typed = 1'b0, input result_t want = '0);
    directed_row_t row;
    row.stim  = '{command: cmd, operand: opd, to_accumulator: on_acc, decimal_flag: dec};
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Loads, logic results, arithmetic, increments and shifts all set N and Z from the new value.
  function automatic void set_nz(input byte_t v);
    shadow.zero     = (v == '0);
    shadow.negative = v[7];
  endfunction

  // Compares set N from the difference, Z on equality and C when no borrow occurs.
  function automatic byte_t compare_against(input byte_t lhs, input byte_t m);
    byte_t diff;
    diff            = lhs - m;
    shadow.negative = diff[7];
    shadow.zero     = (lhs == m);
    shadow.carry    = (lhs >= m);
    return diff;
  endfunction

  // Executes one instruction on the shadow state and returns the result the block
  // must produce for it.
  function automatic result_t execute_item(input item_t it);
    result_t    r;
    byte_t      addend;
    byte_t      src;
    byte_t      shifted;
    logic [8:0] sum;
    r           = '0;
    r.value_out = shadow.acc;
    case (it.command)
      CMD_LDA: begin
        shadow.acc = it.operand;
        set_nz(it.operand);
        r.value_out = it.operand;
      end
      CMD_LDX: begin
        shadow.idx_x = it.operand;
        set_nz(it.operand);
        r.value_out = it.operand;
      end
      CMD_LDY: begin
        shadow.idx_y = it.operand;
        set_nz(it.operand);
        r.value_out = it.operand;
      end
      CMD_AND, CMD_EOR, CMD_ORA: begin
        if (it.command == CMD_AND) begin
          shadow.acc = shadow.acc & it.operand;
        end else if (it.command == CMD_EOR) begin
          shadow.acc = shadow.acc ^ it.operand;
        end else begin
          shadow.acc = shadow.acc | it.operand;
        end
        set_nz(shadow.acc);
        r.value_out = shadow.acc;
      end
      CMD_BIT: begin
        // BIT tests A AND M for Z but takes N and V straight from the operand.
        shadow.zero     = ((shadow.acc & it.operand) == '0);
        shadow.overflow = it.operand[6];
        shadow.negative = it.operand[7];
      end
      CMD_ADC, CMD_SBC: begin
        if (it.decimal_flag) begin
          // Decimal arithmetic is refused: no state moves, only the error is raised.
          r.decimal_error = 1'b1;
        end else begin
          // Subtract is add of the one's complement; carry in acts as not-borrow.
          addend = (it.command == CMD_SBC) ? ~it.operand : it.operand;
          sum    = {1'b0, shadow.acc} + {1'b0, addend} + {8'd0, shadow.carry};
          shadow.overflow = ~(shadow.acc[7] ^ addend[7]) & (shadow.acc[7] ^ sum[7]);
          shadow.carry    = sum[8];
          shadow.acc      = sum[7:0];
          set_nz(shadow.acc);
          r.value_out = shadow.acc;
        end
      end
      CMD_CMP: r.value_out = compare_against(shadow.acc, it.operand);
      CMD_CPX: r.value_out = compare_against(shadow.idx_x, it.operand);
      CMD_CPY: r.value_out = compare_against(shadow.idx_y, it.operand);
      CMD_INX, CMD_DEX: begin
        shadow.idx_x = (it.command == CMD_INX) ? shadow.idx_x + 8'd1 : shadow.idx_x - 8'd1;
        set_nz(shadow.idx_x);
        r.value_out = shadow.idx_x;
      end
      CMD_INY, CMD_DEY: begin
        shadow.idx_y = (it.command == CMD_INY) ? shadow.idx_y + 8'd1 : shadow.idx_y - 8'd1;
        set_nz(shadow.idx_y);
        r.value_out = shadow.idx_y;
      end
      CMD_INC, CMD_DEC: begin
        r.value_out    = (it.command == CMD_INC) ? it.operand + 8'd1 : it.operand - 8'd1;
        r.write_memory = 1'b1;
        set_nz(r.value_out);
      end
      CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
        src = it.to_accumulator ? shadow.acc : it.operand;
        // Rotates feed the old carry in before the bit shifted out replaces it.
        if (it.command == CMD_ASL || it.command == CMD_ROL) begin
          shifted      = {src[6:0], (it.command == CMD_ROL) ? shadow.carry : 1'b0};
          shadow.carry = src[7];
        end else begin
          shifted      = {(it.command == CMD_ROR) ? shadow.carry : 1'b0, src[7:1]};
          shadow.carry = src[0];
        end
        set_nz(shifted);
        r.value_out = shifted;
        if (it.to_accumulator) begin
          shadow.acc = shifted;
        end else begin
          r.write_memory = 1'b1;
        end
      end
      default: begin
        // Undefined command: the accumulator is echoed and nothing changes.
      end
    endcase
    r.carry_out    = shadow.carry;
    r.zero_out     = shadow.zero;
    r.overflow_out = shadow.overflow;
    r.negative_out = shadow.negative;
    return r;
  endfunction

  // Most gaps are short or absent, a few are long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  // Random instruction. Operands lean toward the byte extremes, where carries and
  // sign changes happen, and a small share of commands are undefined codes.
  function automatic item_t random_item();
    item_t       it;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      it.command = CmdWidth'($urandom_range(22, 31));
    end else begin
      it.command = CmdWidth'($urandom_range(0, 21));
    end
    case ($urandom_range(0, 9))
      0:       it.operand = 8'h00;
      1:       it.operand = 8'hFF;
      2:       it.operand = 8'h7F;
      3:       it.operand = 8'h80;
      4:       it.operand = 8'h01;
      default: it.operand = byte_t'($urandom_range(0, 255));
    endcase
    it.to_accumulator = 1'($urandom_range(0, 1));
    it.decimal_flag   = ($urandom_range(0, 6) == 0);
    return it;
  endfunction

  function automatic string describe(input result_t r);
    return $sformatf("value %h wmem %b C %b Z %b V %b N %b derr %b", r.value_out,
                     r.write_memory, r.carry_out, r.zero_out, r.overflow_out,
                     r.negative_out, r.decimal_error);
  endfunction

  function automatic void note_mismatch(input string what, input result_t want,
                                        input result_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("ERROR at %0t: %s", $realtime, what);
      $display("  expected %s", describe(want));
      $display("  actual   %s", describe(got));
    end
  endfunction

  // Offers one instruction, starting and ending at a falling edge, and records its
  // expected result at the rising edge where the transfer happens. The valid line
  // is written at most once per edge: it is only lowered when a gap follows.
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    int unsigned gap;
    result_t     predicted;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.command        <= it.command;
    item_ch.operand        <= it.operand;
    item_ch.to_accumulator <= it.to_accumulator;
    item_ch.decimal_flag   <= it.decimal_flag;
    item_ch.valid          <= 1'b1;
    do begin
      @(posedge clk);
    end while (!item_ch.ready);
    // The predictor still runs on typed rows so that its state follows the block.
    predicted = execute_item(it);
    pending_results.push_back(typed ? want : predicted);
    if (predicted.decimal_error) begin
      refusals++;
    end
    items_sent++;
    @(negedge clk);
  endtask

  // Sender: reset, the directed table, then the random instructions, then the drain.
  initial begin
    item_ch.valid          = 1'b0;
    item_ch.command        = '0;
    item_ch.operand        = '0;
    item_ch.to_accumulator = 1'b0;
    item_ch.decimal_flag   = 1'b0;
    shadow                 = '0;

    // Typed rows list their fields in the order value, wmem, C, Z, V, N, derr.
    add_row(CMD_LDA, 8'h00, 1'b0, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
    add_row(CMD_LDA, 8'hFF, 1'b0, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0});
    add_row(CMD_LDX, 8'hFF, 1'b0, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0});
    add_row(CMD_AND, 8'h0F);
    add_row(CMD_EOR, 8'hFF);
    add_row(CMD_ORA, 8'h0F);
    add_row(CMD_BIT, 8'hC0);
    add_row(CMD_LDA, 8'h7F);
    // 0x7F + 1 overflows into the sign bit; carry is still clear from reset.
    add_row(CMD_ADC, 8'h01);
    // Decimal add and subtract are refused and report A = 0x80 with unchanged flags.
    add_row(CMD_ADC, 8'h80, 1'b0, 1'b1, 1'b1, '{8'h80, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1});
    add_row(CMD_SBC, 8'h01, 1'b1, 1'b1, 1'b1, '{8'h80, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1});
    add_row(CMD_SBC, 8'h01);
    add_row(CMD_CMP, 8'h7E);
    add_row(CMD_CPX, 8'hFF);
    add_row(CMD_CPY, 8'hFF);
    // X sits at 0xFF, so the X steps wrap around both ends.
    add_row(CMD_INX, 8'h00);
    add_row(CMD_DEX, 8'h00);
    add_row(CMD_INY, 8'hFF);
    add_row(CMD_DEY, 8'h00);
    add_row(CMD_INC, 8'hFF);
    add_row(CMD_DEC, 8'h00);
    add_row(CMD_ASL, 8'h00, 1'b1);
    add_row(CMD_LSR, 8'h81, 1'b0);
    add_row(CMD_ROL, 8'h55, 1'b1);
    add_row(CMD_ROR, 8'h01, 1'b0);
    add_row(CmdUndefined, 8'hA5, 1'b1, 1'b1);

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    end
    // A window in the middle of the random part runs with no gaps on either side.
    for (int unsigned n = 0; n < RandomItems; n++) begin
      steady = (n >= 400 && n < 520);
      send_item(random_item(), 1'b0, '0);
    end
    item_ch.valid <= 1'b0;

    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TailCycles) @(posedge clk);

    $display("Ran %0d directed and %0d random instructions; %0d results checked,",
             directed_rows.size(), items_sent - directed_rows.size(), results_checked);
    $display("including %0d decimal-mode refusals and one long result stall.", refusals);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: random stalls, no stalls during the steady window, and one long
  // hold-off while the sender keeps offering, so that both stages of the block
  // fill up and the item side sees ready drop.
  initial begin
    int unsigned gap;
    result_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!hold_done && items_sent >= 300) begin
        result_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_done = 1'b1;
      end else if (steady) begin
        result_ch.ready <= 1'b1;
        @(negedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          result_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  // Result checker: every result transfer is matched against the oldest
  // expectation. Inputs move on falling edges, so the values seen here are stable.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.value_out     = result_ch.value_out;
      got.write_memory  = result_ch.write_memory;
      got.carry_out     = result_ch.carry_out;
      got.zero_out      = result_ch.zero_out;
      got.overflow_out  = result_ch.overflow_out;
      got.negative_out  = result_ch.negative_out;
      got.decimal_error = result_ch.decimal_error;
      if (pending_results.size() == 0) begin
        note_mismatch("result transfer with nothing expected", '0, got);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.value_out !== want.value_out || got.write_memory !== want.write_memory ||
            got.carry_out !== want.carry_out || got.zero_out !== want.zero_out ||
            got.overflow_out !== want.overflow_out ||
            got.negative_out !== want.negative_out ||
            got.decimal_error !== want.decimal_error) begin
          note_mismatch($sformatf("result %0d differs", results_checked), want, got);
        end
      end
    end
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
